// ===== design/s8p_pkg.sv =====
// Shared types, selector tables and the width classifier for the Simple-8b packer.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps

package s8p_pkg;

  localparam int WINDOW_DEPTH_DEF = 240;
  localparam int VALUE_W          = 60;
  localparam int WORD_W           = 64;
  localparam int SEL_W            = 4;
  localparam int SEL_COUNT        = 16;
  localparam int CLASS_COUNT      = 15;
  localparam int ITEMS_W          = 8;
  localparam int BITS_W           = 6;
  localparam int POS_W            = 7;

  // Input mode codes
  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  typedef struct packed {
    logic               mode;
    logic [VALUE_W-1:0] value;
  } in_req_t;

  typedef struct packed {
    logic [WORD_W-1:0] packed_word;
    logic              window_empty;
  } out_req_t;

  // Per-cycle controls broadcast along the cell row
  typedef struct packed {
    logic shift_val;  // move every value one cell towards the head
    logic load_cp;    // reload the scan copy of the width classes
    logic shift_cp;   // move the scan copy one cell towards the head
  } cell_ctl_t;

  // Item count of each selector
  localparam logic [ITEMS_W-1:0] SEL_ITEMS [SEL_COUNT] = '{
    8'd240, 8'd120, 8'd60, 8'd30, 8'd20, 8'd15, 8'd12, 8'd10,
    8'd8,   8'd7,   8'd6,  8'd5,  8'd4,  8'd3,  8'd2,  8'd1
  };

  // Slot width of each selector
  localparam logic [BITS_W-1:0] SEL_BITS [SEL_COUNT] = '{
    6'd0, 6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd5, 6'd6,
    6'd7, 6'd8, 6'd10, 6'd12, 6'd15, 6'd20, 6'd30, 6'd60
  };

  // Width class of each selector: index into CLASS_BITS
  localparam logic [SEL_W-1:0] SEL_CLASS [SEL_COUNT] = '{
    4'd0, 4'd0, 4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
    4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12, 4'd13, 4'd14
  };

  // Distinct slot widths, ascending
  localparam int CLASS_BITS [CLASS_COUNT] = '{
    0, 1, 2, 3, 4, 5, 6, 7, 8, 10, 12, 15, 20, 30, 60
  };

  // Smallest width class that holds the value
  function automatic logic [SEL_W-1:0] value_class(input logic [VALUE_W-1:0] v);
    logic [SEL_W-1:0] c;
    c = SEL_W'(CLASS_COUNT - 1);
    for (int i = CLASS_COUNT - 2; i >= 0; i--) begin
      if ((v >> CLASS_BITS[i]) == '0) begin
        c = SEL_W'(i);
      end
    end
    return c;
  endfunction

endpackage

// ===== design/simple8b_integer_packer.sv =====
// Simple-8b packer top level: cell row, selector scan, word assembly and output register.
// Depends on s8p_pkg, s8p_cell and s8p_packer.
`timescale 1ns / 1ps

// Usage:
//  in_valid/in_stall/in_data carry requests: mode 0 pushes a 60-bit value,
//  mode 1 drains one word at the end of the stream. out_valid/out_stall/out_data
//  carry one Simple-8b word and a flag that the window is empty afterwards.
//  A push that leaves the window short of full gives no word.
//  The push that fills the window, or a drain with values pending, starts a word:
//  the block scans the width classes from the head, one cell per cycle, stepping
//  to the next selector whenever a class is too wide, then pops the chosen items
//  one per cycle into the word. A drain with nothing pending gives no word.
//  The word sits in an output register; while the receiver stalls, further pushes
//  are still taken, and only a finished word that cannot be handed over waits.
//  Reset empties the window and drops any word in flight; no clearing pass.
module simple8b_integer_packer #(
  parameter int WINDOW_DEPTH = s8p_pkg::WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  s8p_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output s8p_pkg::out_req_t out_data
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_PACK = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CNT_W-1:0]               count_r, count_nxt;
  logic [CNT_W-1:0]               j_r, j_nxt;
  logic [CNT_W-1:0]               got_r, got_nxt;
  logic [s8p_pkg::SEL_W-1:0]      sel_r, sel_nxt;
  logic                           out_valid_r, out_valid_nxt;
  s8p_pkg::out_req_t              out_data_r, out_data_nxt;

  s8p_pkg::cell_ctl_t             ctl;
  logic                           accept, push_wr;
  logic [s8p_pkg::SEL_W-1:0]      in_cls;
  logic [CNT_W-1:0]               lim;
  logic [CNT_W-1:0]               sel_items;
  logic                           pk_start, pk_add;
  logic [s8p_pkg::WORD_W-1:0]     pk_word;
  logic                           out_free;

  logic [s8p_pkg::VALUE_W-1:0]    val_w [WINDOW_DEPTH];
  logic [s8p_pkg::SEL_W-1:0]      cls_w [WINDOW_DEPTH];
  logic [s8p_pkg::SEL_W-1:0]      cp_w  [WINDOW_DEPTH];

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign push_wr  = accept && (in_data.mode == s8p_pkg::MODE_PUSH) &&
                    (count_r < CNT_W'(WINDOW_DEPTH));
  assign in_cls   = s8p_pkg::value_class(in_data.value);
  assign out_free = !out_valid_r || !out_stall;

  // Items the current selector needs, capped at what is pending
  assign sel_items = CNT_W'(s8p_pkg::SEL_ITEMS[sel_r]);
  assign lim       = (sel_items < count_r) ? sel_items : count_r;

  // Row of window cells, head at index 0
  for (genvar k = 0; k < WINDOW_DEPTH; k++) begin : g_cell
    logic                        wr_k;
    logic [s8p_pkg::VALUE_W-1:0] nb_val;
    logic [s8p_pkg::SEL_W-1:0]   nb_cls, nb_cp;
    assign wr_k = push_wr && (count_r == CNT_W'(k));
    if (k == WINDOW_DEPTH - 1) begin : g_tail
      assign nb_val = '0;
      assign nb_cls = '0;
      assign nb_cp  = '0;
    end else begin : g_mid
      assign nb_val = val_w[k+1];
      assign nb_cls = cls_w[k+1];
      assign nb_cp  = cp_w[k+1];
    end
    s8p_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .wr     (wr_k),
      .wr_val (in_data.value),
      .wr_cls (in_cls),
      .nb_val (nb_val),
      .nb_cls (nb_cls),
      .nb_cp  (nb_cp),
      .val_o  (val_w[k]),
      .cls_o  (cls_w[k]),
      .cp_o   (cp_w[k])
    );
  end

  s8p_packer u_packer (
    .clk    (clk),
    .start  (pk_start),
    .sel    (sel_r),
    .add    (pk_add),
    .val    (val_w[0]),
    .word_o (pk_word)
  );

  // Sequence: collect, scan for the selector, pop items, hand over the word
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    j_nxt         = j_r;
    got_nxt       = got_r;
    sel_nxt       = sel_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctl           = '0;
    pk_start      = 1'b0;
    pk_add        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        ctl.load_cp = 1'b1;
        j_nxt       = '0;
        sel_nxt     = '0;
        if (push_wr) begin
          count_nxt = count_r + CNT_W'(1);
          if (count_r == CNT_W'(WINDOW_DEPTH - 1)) begin
            state_nxt = ST_SCAN;
          end
        end else if (accept && (in_data.mode == s8p_pkg::MODE_DRAIN) &&
                     (count_r != '0)) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        priority if (j_r >= lim) begin
          got_nxt   = lim;
          pk_start  = 1'b1;
          state_nxt = ST_PACK;
        end else if (cp_w[0] > s8p_pkg::SEL_CLASS[sel_r]) begin
          sel_nxt = sel_r + s8p_pkg::SEL_W'(1);
        end else begin
          j_nxt        = j_r + CNT_W'(1);
          ctl.shift_cp = 1'b1;
        end
      end
      ST_PACK: begin
        pk_add        = 1'b1;
        ctl.shift_val = 1'b1;
        count_nxt     = count_r - CNT_W'(1);
        got_nxt       = got_r - CNT_W'(1);
        if (got_r == CNT_W'(1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.packed_word  = pk_word;
          out_data_nxt.window_empty = (count_r == '0);
          state_nxt                 = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Scan and payload registers
  always_ff @(posedge clk) begin
    j_r        <= j_nxt;
    got_r      <= got_nxt;
    sel_r      <= sel_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Window never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(WINDOW_DEPTH))
    else $error("window count beyond depth");

  // Scan position stays within the pending values
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (j_r <= count_r) && (count_r != '0))
    else $error("scan position beyond pending values");

  // Popping never takes more than is pending
  a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PACK) |-> (got_r != '0) && (got_r <= count_r))
    else $error("pop count inconsistent with window");

  // A finished word only enters a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && out_valid_r && out_stall |=> (state_r == ST_EMIT))
    else $error("word handed over while output busy");

endmodule

// ===== design/s8p_cell.sv =====
// One window cell: a pending value, its width class and a scan copy of the class.
// Depends on s8p_pkg for widths and the control struct.
`timescale 1ns / 1ps

module s8p_cell (
  input  logic                            clk,
  input  s8p_pkg::cell_ctl_t              ctl,
  input  logic                            wr,
  input  logic [s8p_pkg::VALUE_W-1:0]     wr_val,
  input  logic [s8p_pkg::SEL_W-1:0]       wr_cls,
  input  logic [s8p_pkg::VALUE_W-1:0]     nb_val,
  input  logic [s8p_pkg::SEL_W-1:0]       nb_cls,
  input  logic [s8p_pkg::SEL_W-1:0]       nb_cp,
  output logic [s8p_pkg::VALUE_W-1:0]     val_o,
  output logic [s8p_pkg::SEL_W-1:0]       cls_o,
  output logic [s8p_pkg::SEL_W-1:0]       cp_o
);

  logic [s8p_pkg::VALUE_W-1:0] val_r;
  logic [s8p_pkg::SEL_W-1:0]   cls_r;
  logic [s8p_pkg::SEL_W-1:0]   cp_r;

  // Take a new request or the neighbour's value
  always_ff @(posedge clk) begin
    if (wr) begin
      val_r <= wr_val;
      cls_r <= wr_cls;
    end else if (ctl.shift_val) begin
      val_r <= nb_val;
      cls_r <= nb_cls;
    end
  end

  // Reload or advance the scan copy of the class
  always_ff @(posedge clk) begin
    if (ctl.load_cp) begin
      cp_r <= wr ? wr_cls : cls_r;
    end else if (ctl.shift_cp) begin
      cp_r <= nb_cp;
    end
  end

  assign val_o = val_r;
  assign cls_o = cls_r;
  assign cp_o  = cp_r;

endmodule

// ===== design/s8p_packer.sv =====
// Word assembler: places the values popped from the window head into a Simple-8b word.
// Depends on s8p_pkg for the selector width table.
`timescale 1ns / 1ps

module s8p_packer (
  input  logic                          clk,
  input  logic                          start,
  input  logic [s8p_pkg::SEL_W-1:0]     sel,
  input  logic                          add,
  input  logic [s8p_pkg::VALUE_W-1:0]   val,
  output logic [s8p_pkg::WORD_W-1:0]    word_o
);

  logic [s8p_pkg::WORD_W-1:0] word_r, word_nxt;
  logic [s8p_pkg::POS_W-1:0]  pos_r, pos_nxt;
  logic [s8p_pkg::BITS_W-1:0] bits;

  assign bits = s8p_pkg::SEL_BITS[sel];

  // Open a word with the selector, or append one slot
  always_comb begin
    word_nxt = word_r;
    pos_nxt  = pos_r;
    if (start) begin
      word_nxt = {{(s8p_pkg::WORD_W - s8p_pkg::SEL_W){1'b0}}, sel};
      pos_nxt  = s8p_pkg::POS_W'(s8p_pkg::SEL_W);
    end else if (add) begin
      word_nxt = word_r |
                 ({{(s8p_pkg::WORD_W - s8p_pkg::VALUE_W){1'b0}}, val} << pos_r);
      pos_nxt  = pos_r + s8p_pkg::POS_W'(bits);
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
    pos_r  <= pos_nxt;
  end

  assign word_o = word_r;

endmodule

// ===== test/simple8b_integer_packer_tb.sv =====
// Testbench for the Simple-8b packer: directed and random push/drain streams,
// checked against a behavioural window model. Depends on s8p_pkg and the top level.
`timescale 1ns / 1ps

module simple8b_integer_packer_tb;

  localparam int DEPTH = s8p_pkg::WINDOW_DEPTH_DEF;
  localparam int STALL_LIMIT = 40000;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  s8p_pkg::in_req_t   in_data;
  logic               out_valid;
  logic               out_stall;
  s8p_pkg::out_req_t  out_data;

  // Window model state
  logic [s8p_pkg::VALUE_W-1:0] win_vals [DEPTH];
  int                          win_count;
  s8p_pkg::out_req_t           word_q [$];

  int  err_count;
  int  sent_count;
  int  word_count;
  int  drain_count;
  bit  calm;
  bit  run_done;
  int  idle_cycles;

  simple8b_integer_packer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h want %h (t=%0t)", what, got, want, $time);
    err_count++;
  endtask

  // Pick the first fitting selector, pack from the window head, drop the items
  function automatic s8p_pkg::out_req_t pack_word(input bit at_end);
    s8p_pkg::out_req_t r;
    logic [63:0] w;
    logic [63:0] lim;
    int shift;
    int got;
    r = '0;
    for (int s = 0; s < s8p_pkg::SEL_COUNT; s++) begin
      lim = (s8p_pkg::SEL_BITS[s] == 0) ? 64'd0 :
            ((64'd1 << s8p_pkg::SEL_BITS[s]) - 64'd1);
      w = 64'(s);
      shift = 4;
      got = 0;
      for (int j = 0; j < win_count; j++) begin
        if (got == int'(s8p_pkg::SEL_ITEMS[s])) break;
        if (64'(win_vals[j]) > lim) break;
        if (shift < 64) w |= 64'(win_vals[j]) << shift;
        shift += s8p_pkg::SEL_BITS[s];
        got++;
      end
      if (got == int'(s8p_pkg::SEL_ITEMS[s]) || (at_end && got == win_count)) begin
        for (int k = 0; k + got < win_count; k++) win_vals[k] = win_vals[k + got];
        win_count -= got;
        r.packed_word = w;
        r.window_empty = (win_count == 0);
        return r;
      end
    end
    return r;
  endfunction

  function automatic void predict_request(input s8p_pkg::in_req_t q);
    if (q.mode == s8p_pkg::MODE_PUSH) begin
      if (win_count >= DEPTH) return;
      win_vals[win_count] = q.value;
      win_count++;
      if (win_count == DEPTH) word_q.insert(word_q.size(), pack_word(1'b0));
    end else if (win_count != 0) begin
      word_q.insert(word_q.size(), pack_word(1'b1));
    end
  endfunction

  // Send one request, idling at random unless in a calm stretch
  task automatic send_request(input logic mode,
                              input logic [s8p_pkg::VALUE_W-1:0] value);
    while (!calm && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{mode: mode, value: value};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request('{mode: mode, value: value});
    sent_count++;
    if (mode == s8p_pkg::MODE_DRAIN) drain_count++;
  endtask

  // Value of a random bit width from 0 up to maxw
  function automatic logic [s8p_pkg::VALUE_W-1:0] rand_value(input int maxw);
    int w;
    logic [s8p_pkg::VALUE_W-1:0] v;
    w = $urandom_range(maxw);
    v = s8p_pkg::VALUE_W'({$urandom, $urandom});
    return (w == 0) ? '0 : (v & ((60'd1 << w) - 60'd1));
  endfunction

  // Hold the input idle until every expected word has arrived
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (word_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Push n values of random bit widths up to maxw
  task automatic push_burst(input int n, input int maxw);
    for (int i = 0; i < n; i++) send_request(s8p_pkg::MODE_PUSH, rand_value(maxw));
  endtask

  task automatic test_directed();
    send_request(s8p_pkg::MODE_DRAIN, '0);               // drain of an empty window
    send_request(s8p_pkg::MODE_PUSH, '1);                // widest value
    send_request(s8p_pkg::MODE_PUSH, '0);
    send_request(s8p_pkg::MODE_PUSH, 60'h555555555555555);
    send_request(s8p_pkg::MODE_PUSH, 60'haaaaaaaaaaaaaaa);
    send_request(s8p_pkg::MODE_PUSH, 60'd1);
    for (int i = 0; i < 6; i++) send_request(s8p_pkg::MODE_DRAIN, '1);
    // partial drains of zeros and of small values
    send_request(s8p_pkg::MODE_PUSH, '0);
    send_request(s8p_pkg::MODE_PUSH, '0);
    send_request(s8p_pkg::MODE_DRAIN, '0);
    for (int i = 0; i < 5; i++) send_request(s8p_pkg::MODE_PUSH, 60'd3);
    send_request(s8p_pkg::MODE_DRAIN, '0);
    send_request(s8p_pkg::MODE_DRAIN, '0);
    wait_drained();
  endtask

  task automatic test_full_zero_window();
    // all zeros give selector 0, then a one after 120 zeros gives selector 1
    push_burst(DEPTH, 0);
    push_burst(120, 0);
    send_request(s8p_pkg::MODE_PUSH, 60'd1);
    push_burst(119, 0);
    while (win_count != 0) send_request(s8p_pkg::MODE_DRAIN, '0);
    wait_drained();
  endtask

  task automatic test_random_streams();
    int n;
    int maxw;
    for (int blk = 0; blk < 8; blk++) begin
      calm = (blk == 4 || blk == 5);
      n = $urandom_range(40, 60);
      maxw = (blk % 3 == 0) ? 60 : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(99) < 3) send_request(s8p_pkg::MODE_DRAIN, rand_value(60));
        else send_request(s8p_pkg::MODE_PUSH, rand_value($urandom_range(maxw)));
      end
      if (blk == 5) begin
        while (win_count != 0) send_request(s8p_pkg::MODE_DRAIN, '0);
        wait_drained();
      end
    end
    calm = 1'b0;
    while (win_count != 0) send_request(s8p_pkg::MODE_DRAIN, '0);
  endtask

  // Result checker and receiver stalls
  always @(posedge clk) begin
    s8p_pkg::out_req_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (word_q.size() == 0) begin
          report_mismatch("unexpected word", out_data.packed_word, '0);
        end else begin
          want = word_q.pop_front();
          word_count++;
          if (out_data.packed_word !== want.packed_word)
            report_mismatch("packed_word", out_data.packed_word, want.packed_word);
          if (out_data.window_empty !== want.window_empty)
            report_mismatch("window_empty", 64'(out_data.window_empty),
                            64'(want.window_empty));
        end
      end
      out_stall <= !calm && ($urandom_range(99) < 32);
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT && !run_done) begin
        $display("timeout: %0d words outstanding", word_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    win_count = 0;
    err_count = 0;
    sent_count = 0;
    word_count = 0;
    drain_count = 0;
    calm = 1'b0;
    run_done = 1'b0;
    idle_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_zero_window();
    test_random_streams();
    wait_drained();
    repeat (600) @(posedge clk);
    run_done = 1'b1;
    if (word_q.size() != 0) begin
      $display("%0d expected words never arrived", word_q.size());
      err_count++;
    end
    $display("covered %0d requests (%0d drains), %0d words checked",
             sent_count, drain_count, word_count);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
